// ----- rtl/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, constants and tables for the cosine cutoff switch.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  localparam int FracBitsDef    = 16;
  localparam int CordicStepsDef = 20;

  // pi in Q30 and the CORDIC start value (1/gain) in Q30
  localparam logic [31:0] PiQ30      = 32'd3373259426;
  localparam logic [31:0] CordicGain = 32'd652032874;

  typedef enum logic [1:0] {
    TAG_LIN,
    TAG_ONE,
    TAG_ZERO,
    TAG_COS
  } tag_e;

  typedef enum logic [2:0] {
    REG_KIND  = 3'd0,
    REG_SLOPE = 3'd1,
    REG_ICPT  = 3'd2,
    REG_LOWER = 3'd3,
    REG_UPPER = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    tag_e        tag;
    logic [31:0] lin;
    logic [31:0] span;
  } div_side_t;

  typedef struct packed {
    tag_e        tag;
    logic [31:0] lin;
    logic [31:0] val;
  } out_side_t;

  function automatic logic [31:0] atan_q30(input int unsigned k);
    logic [31:0] r;
    case (k)
      0:       r = 32'h3243F6A8;
      1:       r = 32'h1DAC6705;
      2:       r = 32'h0FADBAFC;
      3:       r = 32'h07F56EA6;
      4:       r = 32'h03FEAB76;
      5:       r = 32'h01FFD55B;
      6:       r = 32'h00FFFAAA;
      7:       r = 32'h007FFF55;
      8:       r = 32'h003FFFEA;
      9:       r = 32'h001FFFFD;
      10:      r = 32'h000FFFFF;
      11:      r = 32'h0007FFFF;
      12:      r = 32'h0003FFFF;
      13:      r = 32'h0001FFFF;
      14:      r = 32'h0000FFFF;
      15:      r = 32'h00007FFF;
      16:      r = 32'h00003FFF;
      17:      r = 32'h00001FFF;
      18:      r = 32'h00000FFF;
      19:      r = 32'h000007FF;
      20:      r = 32'h000003FF;
      21:      r = 32'h000001FF;
      22:      r = 32'h000000FF;
      23:      r = 32'h0000007F;
      24:      r = 32'h0000003F;
      25:      r = 32'h0000001F;
      26:      r = 32'h0000000F;
      27:      r = 32'h00000007;
      28:      r = 32'h00000003;
      29:      r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ccs_div.sv -----
// ----------------------------------------------------------------------------
// ccs_div
// Pipelined restoring divider, one quotient bit per stage.
// q = (rem_i * 2^NW + num_i) / den_i, with rem_i < den_i.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_div #(
  parameter int NW = 30,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic      [NW-1:0] quo_o,
  output logic      [SW-1:0] side_o
);

  logic          v_s    [0:NW];
  logic [DW-1:0] r_s    [0:NW];
  logic [NW-1:0] n_s    [0:NW];
  logic [NW-1:0] q_s    [0:NW];
  logic [DW-1:0] d_s    [0:NW];
  logic [SW-1:0] side_s [0:NW];

  assign v_s[0]    = valid_i;
  assign r_s[0]    = rem_i;
  assign n_s[0]    = num_i;
  assign q_s[0]    = '0;
  assign d_s[0]    = den_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] rr;
    logic [DW:0] diff;
    logic        ge;

    assign rr   = {r_s[k], n_s[k][NW-1]};
    assign ge   = rr >= {1'b0, d_s[k]};
    assign diff = rr - {1'b0, d_s[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_s[k+1]    <= ge ? diff[DW-1:0] : rr[DW-1:0];
        n_s[k+1]    <= n_s[k] << 1;
        q_s[k+1]    <= {q_s[k][NW-2:0], ge};
        d_s[k+1]    <= d_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = v_s[NW];
  assign quo_o   = q_s[NW];
  assign side_o  = side_s[NW];

endmodule

`default_nettype wire

// ----- rtl/ccs_cordic.sv -----
// ----------------------------------------------------------------------------
// ccs_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// Starts at (1/gain, 0) and returns cos and sin of the Q30 angle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_cordic #(
  parameter int STEPS = ccs_pkg::CordicStepsDef,
  parameter int XW    = 34,
  parameter int ZW    = 34,
  parameter int SW    = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [ZW-1:0] angle_i,
  input  wire logic        [SW-1:0] side_i,
  output logic                      valid_o,
  output logic signed      [XW-1:0] cos_o,
  output logic signed      [XW-1:0] sin_o,
  output logic             [SW-1:0] side_o
);

  logic                 v_s    [0:STEPS];
  logic signed [XW-1:0] x_s    [0:STEPS];
  logic signed [XW-1:0] y_s    [0:STEPS];
  logic signed [ZW-1:0] z_s    [0:STEPS];
  logic        [SW-1:0] side_s [0:STEPS];

  assign v_s[0]    = valid_i;
  assign x_s[0]    = XW'(ccs_pkg::CordicGain);
  assign y_s[0]    = '0;
  assign z_s[0]    = angle_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] at;

    assign dx = y_s[k] >>> k;
    assign dy = x_s[k] >>> k;
    assign at = ZW'(ccs_pkg::atan_q30(k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_s[k][ZW-1]) begin
          x_s[k+1] <= x_s[k] - dx;
          y_s[k+1] <= y_s[k] + dy;
          z_s[k+1] <= z_s[k] - at;
        end else begin
          x_s[k+1] <= x_s[k] + dx;
          y_s[k+1] <= y_s[k] - dy;
          z_s[k+1] <= z_s[k] + at;
        end
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = v_s[STEPS];
  assign cos_o   = x_s[STEPS];
  assign sin_o   = y_s[STEPS];
  assign side_o  = side_s[STEPS];

endmodule

`default_nettype wire

// ----- rtl/cosine_cutoff_switch.sv -----
// ----------------------------------------------------------------------------
// cosine_cutoff_switch
// Switching function (linear or cosine step-down) and its derivative.
//
//   port group   direction  handshake               payload
//   in           sink       in_valid_i/in_ready_o   abscissa_i
//   out          source     out_valid_o/out_ready_i func_value_o, func_slope_o
//   cfg          sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per cycle in and out while the skid entry is empty. The
// pipeline runs through the 30-stage angle divider, the CORDIC stages and
// the derivative divider. Reset clears the configuration registers and all
// valid bits. A stalled output is held in the output register plus one skid
// entry; the pipeline freezes when the skid entry is full and in_ready_o
// follows it from a register.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_cutoff_switch #(
  parameter int FRAC_BITS    = ccs_pkg::FracBitsDef,
  parameter int CORDIC_STEPS = ccs_pkg::CordicStepsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] abscissa_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] func_value_o,
  output logic      [31:0] func_slope_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int XW   = 34;
  localparam int ZW   = 34;
  localparam int VW   = XW + 2;
  localparam int PW   = XW + 32;
  localparam int MW   = XW + 1;
  localparam int SH   = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int SH2  = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
  localparam int DW2  = 32 + SH2;
  localparam int NUMW = MW + 1 + SH + SH2;
  localparam int SW   = $bits(ccs_pkg::div_side_t);

  localparam logic signed [64:0]   LinHalf = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [VW-1:0] ValHalf = VW'(64'd1 << (29 - FRAC_BITS));
  localparam logic signed [VW-1:0] OneV    = VW'(64'd1 << FRAC_BITS);
  localparam logic        [31:0]   One     = 32'(64'd1 << FRAC_BITS);

  // configuration
  logic               kind_q;
  logic signed [31:0] slope_q;
  logic signed [31:0] icpt_q;
  logic signed [31:0] lower_q;
  logic signed [31:0] upper_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= 1'b0;
      slope_q <= '0;
      icpt_q  <= '0;
      lower_q <= '0;
      upper_q <= '0;
    end else if (cfg_valid_i) begin
      case (ccs_pkg::cfg_reg_e'(cfg_index_i))
        ccs_pkg::REG_KIND:  kind_q  <= cfg_data_i[0];
        ccs_pkg::REG_SLOPE: slope_q <= cfg_data_i;
        ccs_pkg::REG_ICPT:  icpt_q  <= cfg_data_i;
        ccs_pkg::REG_LOWER: lower_q <= cfg_data_i;
        ccs_pkg::REG_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_ready_o = !skid_v_q;

  // stage A: classify, differences, linear product
  logic signed [31:0] x_w;
  logic signed [32:0] num_w;
  logic signed [32:0] span_w;
  logic signed [63:0] prod_w;
  ccs_pkg::tag_e      tag_w;

  assign x_w    = abscissa_i;
  assign num_w  = {x_w[31], x_w} - {lower_q[31], lower_q};
  assign span_w = {upper_q[31], upper_q} - {lower_q[31], lower_q};
  assign prod_w = x_w * slope_q;

  always_comb begin
    if (!kind_q) begin
      tag_w = ccs_pkg::TAG_LIN;
    end else if (x_w <= lower_q) begin
      tag_w = ccs_pkg::TAG_ONE;
    end else if (x_w >= upper_q) begin
      tag_w = ccs_pkg::TAG_ZERO;
    end else begin
      tag_w = ccs_pkg::TAG_COS;
    end
  end

  logic               a_v_q;
  ccs_pkg::tag_e      a_tag_q;
  logic        [31:0] a_num_q;
  logic        [31:0] a_span_q;
  logic signed [63:0] a_prod_q;

  // stage B: linear result
  logic signed [64:0] lrnd_w;
  logic signed [64:0] lsh_w;
  logic signed [65:0] lsum_w;

  assign lrnd_w = {a_prod_q[63], a_prod_q} + LinHalf;
  assign lsh_w  = lrnd_w >>> FRAC_BITS;
  assign lsum_w = {lsh_w[64], lsh_w} + 66'(icpt_q);

  logic                b_v_q;
  ccs_pkg::div_side_t  b_side_q;
  logic         [31:0] b_num_q;

  // angle divider
  logic               d1_v;
  logic        [29:0] d1_t;
  ccs_pkg::div_side_t d1_side;

  ccs_div #(
    .NW (30),
    .DW (32),
    .SW (SW)
  ) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_v_q),
    .rem_i   (b_num_q),
    .num_i   ('0),
    .den_i   (b_side_q.span),
    .side_i  (b_side_q),
    .valid_o (d1_v),
    .quo_o   (d1_t),
    .side_o  (d1_side)
  );

  // stage P: (t - 1/2) * pi
  logic signed [30:0] ts_w;
  logic signed [63:0] phip_w;

  assign ts_w   = $signed({1'b0, d1_t}) - $signed(31'h2000_0000);
  assign phip_w = ts_w * $signed({1'b0, ccs_pkg::PiQ30});

  logic               p_v_q;
  ccs_pkg::div_side_t p_side_q;
  logic signed [63:0] p_prod_q;

  // stage Q: round to Q30 angle
  logic signed [63:0] phir_w;
  assign phir_w = p_prod_q + 64'sd536870912;

  logic               q_v_q;
  ccs_pkg::div_side_t q_side_q;
  logic signed [ZW-1:0] q_phi_q;

  // CORDIC
  logic                 cs_v;
  logic signed [XW-1:0] cs_cos;
  logic signed [XW-1:0] cs_sin;
  ccs_pkg::div_side_t   cs_side;

  ccs_cordic #(
    .STEPS (CORDIC_STEPS),
    .XW    (XW),
    .ZW    (ZW),
    .SW    (SW)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q_v_q),
    .angle_i (q_phi_q),
    .side_i  (q_side_q),
    .valid_o (cs_v),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin),
    .side_o  (cs_side)
  );

  // stage R: function value, pi*cos product
  logic signed [XW-1:0] sh_w;
  logic signed [VW-1:0] v30_w;
  logic signed [VW-1:0] vr_w;
  logic        [31:0]   val_w;
  logic        [XW-1:0] ccl_w;
  logic        [PW-1:0] mp_w;

  assign sh_w  = cs_sin >>> 1;
  assign v30_w = VW'(64'sd536870912) - VW'(sh_w);
  assign vr_w  = (v30_w + ValHalf) >>> (30 - FRAC_BITS);
  assign ccl_w = cs_cos[XW-1] ? '0 : cs_cos;
  assign mp_w  = PW'(ccs_pkg::PiQ30) * PW'(ccl_w);

  always_comb begin
    if (vr_w < 0) begin
      val_w = '0;
    end else if (vr_w > OneV) begin
      val_w = One;
    end else begin
      val_w = vr_w[31:0];
    end
  end

  logic               r_v_q;
  ccs_pkg::div_side_t r_side_q;
  logic        [31:0] r_val_q;
  logic      [PW-1:0] r_mp_q;

  // stage S: derivative numerator and divisor
  logic [MW-1:0]   m_w;
  logic [DW2-1:0]  dd_w;
  logic [NUMW-1:0] n2_w;

  assign m_w  = r_mp_q[PW-1:31];
  assign dd_w = DW2'(r_side_q.span) << SH2;
  assign n2_w = (NUMW'(m_w) << SH) + NUMW'(dd_w >> 1);

  logic               s_v_q;
  ccs_pkg::out_side_t s_side_q;
  logic  [NUMW-1:0]   s_num_q;
  logic  [DW2-1:0]    s_dd_q;

  // derivative divider
  logic               d2_v;
  logic [NUMW-1:0]    d2_q;
  ccs_pkg::out_side_t d2_side;

  ccs_div #(
    .NW (NUMW),
    .DW (DW2),
    .SW ($bits(ccs_pkg::out_side_t))
  ) u_div_m (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_v_q),
    .rem_i   ('0),
    .num_i   (s_num_q),
    .den_i   (s_dd_q),
    .side_i  (s_side_q),
    .valid_o (d2_v),
    .quo_o   (d2_q),
    .side_o  (d2_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      p_v_q <= 1'b0;
      q_v_q <= 1'b0;
      r_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      p_v_q <= d1_v;
      q_v_q <= p_v_q;
      r_v_q <= cs_v;
      s_v_q <= r_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_tag_q       <= tag_w;
      a_num_q       <= num_w[31:0];
      a_span_q      <= span_w[31:0];
      a_prod_q      <= prod_w;
      b_side_q.tag  <= a_tag_q;
      b_side_q.lin  <= ccs_pkg::sat32(lsum_w);
      b_side_q.span <= a_span_q;
      b_num_q       <= a_num_q;
      p_side_q      <= d1_side;
      p_prod_q      <= phip_w;
      q_side_q      <= p_side_q;
      q_phi_q       <= phir_w[ZW+29:30];
      r_side_q      <= cs_side;
      r_val_q       <= val_w;
      r_mp_q        <= mp_w;
      s_side_q.tag  <= r_side_q.tag;
      s_side_q.lin  <= r_side_q.lin;
      s_side_q.val  <= r_val_q;
      s_num_q       <= n2_w;
      s_dd_q        <= dd_w;
    end
  end

  // result select
  logic [31:0] tail_val;
  logic [31:0] tail_slope;
  logic [31:0] cos_slope;

  assign cos_slope = (|d2_q[NUMW-1:31]) ? 32'h8000_0000 : (32'd0 - d2_q[31:0]);

  always_comb begin
    case (d2_side.tag)
      ccs_pkg::TAG_LIN: begin
        tail_val   = d2_side.lin;
        tail_slope = slope_q;
      end
      ccs_pkg::TAG_ONE: begin
        tail_val   = One;
        tail_slope = '0;
      end
      ccs_pkg::TAG_COS: begin
        tail_val   = d2_side.val;
        tail_slope = cos_slope;
      end
      default: begin
        tail_val   = '0;
        tail_slope = '0;
      end
    endcase
  end

  // output register and skid entry
  logic        out_v_q;
  logic [31:0] out_val_q;
  logic [31:0] out_slope_q;
  logic [31:0] skid_val_q;
  logic [31:0] skid_slope_q;
  logic        out_free;

  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || d2_v;
      skid_v_q <= 1'b0;
    end else if (d2_v && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_val_q   <= skid_val_q;
        out_slope_q <= skid_slope_q;
      end else begin
        out_val_q   <= tail_val;
        out_slope_q <= tail_slope;
      end
    end else if (en) begin
      skid_val_q   <= tail_val;
      skid_slope_q <= tail_slope;
    end
  end

  assign out_valid_o  = out_v_q;
  assign func_value_o = out_val_q;
  assign func_slope_o = out_slope_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds data while output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid entry filled without an output stall");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_ready_i && !skid_v_q && !d2_v |=> !out_v_q)
    else $error("output transaction repeated");

endmodule

`default_nettype wire

// ----- test/cosine_cutoff_switch_test.sv -----
// ----------------------------------------------------------------------------
// cosine_cutoff_switch_test
// Self-checking testbench for the cosine cutoff switch. A predictor models
// the linear and cosine step-down modes with the CORDIC at full precision.
// A queue-fed driver and a monitor run against random stalls on both
// channels. The stimulus runs through directed edge cases and then random
// configuration phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cosine_cutoff_switch_test;

  localparam int     WatchdogLimit = 2000;
  localparam int     DrainCycles   = 120;
  localparam longint PiFix         = 64'd3373259426;
  localparam longint GainFix       = 64'd652032874;
  localparam longint OneFix        = 64'd65536;

  localparam longint ArcTan [20] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF
  };

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] slope;
  } switch_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] abscissa_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] func_value_o;
  logic [31:0] func_slope_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic        kind_q;
  logic [31:0] slope_q, icpt_q, lower_q, upper_q;

  logic [31:0]  pending_x [$];
  switch_out_t  expected_out [$];
  int           n_queued, n_accepted, errors, stall_count, in_gap, out_gap;
  bit           in_taken, quiet;

  always #6 clk_i = ~clk_i;

  cosine_cutoff_switch u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .abscissa_i,
    .out_valid_o, .out_ready_i, .func_value_o, .func_slope_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic switch_out_t switch_eval(input logic [31:0] xr);
    switch_out_t r;
    longint x, m, lo, hi, d, num, t, phi, cx, cy, z, dx, dy, v30, val, mq, q;
    x = longint'($signed(xr));
    if (!kind_q) begin
      m = longint'($signed(slope_q));
      r.value = clamp32((((m * x) + 64'sd32768) >>> 16) + longint'($signed(icpt_q)));
      r.slope = slope_q;
      return r;
    end
    lo = longint'($signed(lower_q));
    hi = longint'($signed(upper_q));
    if (x <= lo) return '{value: 32'h0001_0000, slope: 32'h0};
    if (x >= hi) return '{value: 32'h0, slope: 32'h0};
    d   = hi - lo;
    num = x - lo;
    t   = (num <<< 30) / d;
    phi = ((t - (64'sd1 <<< 29)) * PiFix + (64'sd1 <<< 29)) >>> 30;
    cx  = GainFix;
    cy  = 0;
    z   = phi;
    for (int i = 0; i < 20; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx; cy = cy + dy; z = z - ArcTan[i];
      end else begin
        cx = cx + dx; cy = cy - dy; z = z + ArcTan[i];
      end
    end
    if (cx < 0) cx = 0;
    v30 = (64'sd1 <<< 29) - (cy >>> 1);
    val = (v30 + 64'sd8192) >>> 14;
    if (val < 0) val = 0;
    if (val > OneFix) val = OneFix;
    mq = (PiFix * cx) >>> 31;
    q  = ((mq <<< 2) + d / 2) / d;
    r.value = val[31:0];
    r.slope = clamp32(-q);
    return r;
  endfunction

  // driver: new payload only once the previous transaction is gone
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_x.size() > 0) begin
          in_valid_i <= 1'b1;
          abscissa_i <= pending_x.pop_front();
          if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 10);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    switch_out_t exp_r;
    if (rst_ni) begin
      stall_count++;
      if (in_valid_i && in_ready_o) begin
        expected_out.push_back(switch_eval(abscissa_i));
        in_taken = 1'b1;
        n_accepted++;
        stall_count = 0;
      end
      if (cfg_valid_i && cfg_ready_o) stall_count = 0;
      if (out_valid_o && out_ready_i) begin
        stall_count = 0;
        if (expected_out.size() == 0) begin
          $error("unexpected transaction: value %h slope %h", func_value_o, func_slope_o);
          errors++;
        end else begin
          exp_r = expected_out.pop_front();
          if (func_value_o !== exp_r.value) begin
            $error("func_value expected %h actual %h", exp_r.value, func_value_o);
            errors++;
          end
          if (func_slope_o !== exp_r.slope) begin
            $error("func_slope expected %h actual %h", exp_r.slope, func_slope_o);
            errors++;
          end
        end
      end
      if (stall_count >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(input ccs_pkg::cfg_reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ccs_pkg::REG_KIND:  kind_q  = data[0];
      ccs_pkg::REG_SLOPE: slope_q = data;
      ccs_pkg::REG_ICPT:  icpt_q  = data;
      ccs_pkg::REG_LOWER: lower_q = data;
      ccs_pkg::REG_UPPER: upper_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_x(input logic [31:0] x);
    pending_x.push_back(x);
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (n_accepted != n_queued || expected_out.size() != 0);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic k, input logic [31:0] s, input logic [31:0] c,
                            input logic [31:0] lo, input logic [31:0] hi);
    write_reg(ccs_pkg::REG_KIND, {$urandom_range(0, 1) ? $urandom : 32'h0} & 32'hFFFF_FFFE | k);
    write_reg(ccs_pkg::REG_SLOPE, s);
    write_reg(ccs_pkg::REG_ICPT, c);
    write_reg(ccs_pkg::REG_LOWER, lo);
    write_reg(ccs_pkg::REG_UPPER, hi);
  endtask

  initial begin
    longint lo, span, hi;
    logic [31:0] xv;
    kind_q = 0; slope_q = 0; icpt_q = 0; lower_q = 0; upper_q = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_x(32'h1234_5678);
    send_x(32'h8000_0000);
    wait_idle();

    set_config(1'b0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_x(32'h0); send_x(32'h1); send_x(32'hFFFF_FFFF);
    send_x(32'h7FFF_FFFF); send_x(32'h8000_0000);
    wait_idle();
    set_config(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_x(32'h7FFF_FFFF); send_x(32'h8000_0000);
    wait_idle();
    set_config(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_x(32'h7FFF_FFFF); send_x(32'h8000_0000);
    wait_idle();

    // unit-wide step
    set_config(1'b1, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_x(32'hFFFF_FFFF); send_x(32'h0); send_x(32'h1); send_x(32'h8000);
    send_x(32'hFFFF); send_x(32'h0001_0000); send_x(32'h7FFF_FFFF);
    wait_idle();
    // steep step saturates the derivative
    write_reg(ccs_pkg::REG_UPPER, 32'h2);
    send_x(32'h1);
    wait_idle();
    // inverted and equal edges
    write_reg(ccs_pkg::REG_LOWER, 32'd100);
    write_reg(ccs_pkg::REG_UPPER, -32'sd100);
    send_x(32'd100); send_x(32'd101); send_x(-32'sd200);
    wait_idle();
    write_reg(ccs_pkg::REG_UPPER, 32'd100);
    send_x(32'd100); send_x(32'd101);
    wait_idle();
    // widest span, and writes to unused indexes
    write_reg(ccs_pkg::REG_LOWER, 32'h8000_0000);
    write_reg(ccs_pkg::REG_UPPER, 32'h7FFF_FFFF);
    write_reg(ccs_pkg::cfg_reg_e'(3'd5), $urandom);
    write_reg(ccs_pkg::cfg_reg_e'(3'd6), $urandom);
    write_reg(ccs_pkg::cfg_reg_e'(3'd7), $urandom);
    send_x(32'h0); send_x(32'h8000_0001); send_x(32'h7FFF_FFFE);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph == 11);
      lo   = longint'($signed($urandom));
      span = (longint'($urandom) & ((64'sd1 <<< $urandom_range(1, 32)) - 1)) + 1;
      hi   = lo + span;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      if ($urandom_range(0, 9) == 0) hi = lo - longint'($urandom_range(0, 1000));
      if (hi < -64'sd2147483648) hi = -64'sd2147483648;
      set_config(ph[0],
                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3_0000) - 32'h1_8000,
                 $urandom, lo[31:0], hi[31:0]);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(ccs_pkg::cfg_reg_e'($urandom_range(5, 7)), $urandom);
      end
      for (int k = 0; k < 118; k++) begin
        if (ph[0] && hi > lo && $urandom_range(0, 9) < 8) begin
          xv = 32'(lo + (longint'($urandom) % (hi - lo + 1)));
        end else if ($urandom_range(0, 1)) begin
          xv = $urandom;
        end else begin
          xv = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
        end
        send_x(xv);
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ccs_pkg.sv
rtl/ccs_div.sv
rtl/ccs_cordic.sv
rtl/cosine_cutoff_switch.sv
test/cosine_cutoff_switch_test.sv
